// ----- rtl/line_profile_mask_stats_macros.svh -----
// ----------------------------------------------------------------------------
// line profile mask stats assertion macros
// concurrent check helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef LINE_PROFILE_MASK_STATS_MACROS_SVH
`define LINE_PROFILE_MASK_STATS_MACROS_SVH

`ifndef SYNTHESIS
`define LPMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPMS_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define LPMS_ASSERT(lbl, clk, rstn, prop, msg)
`define LPMS_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ----- rtl/lpms_pkg.sv -----
// ----------------------------------------------------------------------------
// lpms_pkg
// types and constants shared by the line profile mask stats block
// ----------------------------------------------------------------------------
package lpms_pkg;

  localparam int unsigned ImgWidthDefault  = 256;
  localparam int unsigned ImgHeightDefault = 256;

  localparam logic        CMD_WRITE = 1'b0;
  localparam logic        CMD_TRACE = 1'b1;

  localparam logic [1:0]  CFG_MAX_FLOOR    = 2'd0;
  localparam logic [1:0]  CFG_FILL_VALUE   = 2'd1;
  localparam logic [1:0]  CFG_GAP_LIMIT    = 2'd2;
  localparam logic [1:0]  CFG_LENGTH_SCALE = 2'd3;

  localparam logic [15:0] MaxFloorReset    = 16'd1;
  localparam logic [15:0] FillValueReset   = 16'hFFFF;
  localparam logic [7:0]  GapLimitReset    = 8'd20;
  localparam logic [3:0]  LengthScaleReset = 4'd4;

  localparam logic [7:0]  MaskMarked   = 8'hFF;
  localparam logic [7:0]  MaskUnmarked = 8'h00;

  typedef struct packed {
    logic              command;
    logic [7:0]        pos_x;
    logic [7:0]        pos_y;
    logic [7:0]        end_x;
    logic [7:0]        end_y;
    logic signed [7:0] mask_value;
    logic [15:0]       chlorophyll;
  } lpms_in_t;

  typedef struct packed {
    logic [15:0] max_chlorophyll;
    logic [15:0] extension_length;
    logic [7:0]  end_row;
  } lpms_out_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic step;
    logic scale;
  } lpms_cmd_t;

  typedef struct packed {
    logic at_end;
  } lpms_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAIL,
    ST_SCALE,
    ST_RESULT
  } lpms_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_GAP
  } lpms_phase_e;

endpackage

// ----- rtl/line_profile_mask_stats.sv -----
// ----------------------------------------------------------------------------
// line_profile_mask_stats
// pixel store with bresenham line tracer returning chlorophyll and mask stats
// ----------------------------------------------------------------------------
// write command: busy stays low, a new command can follow at once
// trace command: busy is high from the walk state through the result state;
// the walk makes one pixel store read per cycle on the single read port,
// then the tail, scaling and result states follow in that order
// done_o is high for one cycle with result_o valid; it cannot be stalled
// reset clears control and configuration; pixel store contents are undefined
module line_profile_mask_stats
  import lpms_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = ImgWidthDefault,
  parameter int unsigned IMG_HEIGHT = ImgHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  lpms_in_t    item_i,
  output logic        done_o,
  output lpms_out_t   result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  lpms_cmd_t cmd;
  lpms_sts_t sts;

  lpms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .busy      (busy),
    .done_o    (done_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  lpms_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

// ----- rtl/lpms_ram.sv -----
// ----------------------------------------------------------------------------
// lpms_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lpms_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lpms_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpms_ctrl
// command sequencer: accepts writes and traces, steps the walk, emits result
// ----------------------------------------------------------------------------
`include "line_profile_mask_stats_macros.svh"

module lpms_ctrl
  import lpms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      command_i,
  output logic      busy,
  output logic      done_o,
  output lpms_cmd_t cmd_o,
  input  lpms_sts_t sts_i
);

  lpms_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (command_i == CMD_TRACE) begin
            cmd_o.load = 1'b1;
            state_d    = ST_WALK;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.at_end) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LPMS_ASSERT(a_trace_walks, clk_i, rst_ni, (start && !busy && command_i == CMD_TRACE) |=> (state_q == ST_WALK), "trace accept did not start walk")
  `LPMS_ASSERT(a_write_no_busy, clk_i, rst_ni, (start && !busy && command_i == CMD_WRITE) |=> !busy, "write command made block busy")
  `LPMS_ASSERT(a_done_after_scale, clk_i, rst_ni, done_o |-> $past(cmd_o.scale), "result strobe without scaling")

endmodule

// ----- rtl/lpms_dp.sv -----
// ----------------------------------------------------------------------------
// lpms_dp
// pixel store, line stepper, profile statistics and configuration registers
// ----------------------------------------------------------------------------
`include "line_profile_mask_stats_macros.svh"

module lpms_dp
  import lpms_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = ImgWidthDefault,
  parameter int unsigned IMG_HEIGHT = ImgHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lpms_in_t    item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  lpms_cmd_t   cmd_i,
  output lpms_sts_t   sts_o,
  output lpms_out_t   result_o
);

  localparam int unsigned Depth = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DimW  = 13;
  localparam int unsigned ErrW  = 11;
  localparam int unsigned CntW  = 10;
  localparam int unsigned ProdW = CntW + 4;

  function automatic logic [AW-1:0] pix_addr(input logic [7:0] px, input logic [7:0] py);
    pix_addr = AW'(AW'(py) * AW'(IMG_WIDTH) + AW'(px));
  endfunction

  function automatic logic in_image(input logic [7:0] px, input logic [7:0] py);
    in_image = ({5'b0, px} < DimW'(IMG_WIDTH)) && ({5'b0, py} < DimW'(IMG_HEIGHT));
  endfunction

  // configuration
  logic [15:0] max_floor_q, fill_value_q;
  logic [7:0]  gap_limit_q;
  logic [3:0]  length_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_floor_q    <= MaxFloorReset;
      fill_value_q   <= FillValueReset;
      gap_limit_q    <= GapLimitReset;
      length_scale_q <= LengthScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_FLOOR:    max_floor_q    <= cfg_wdata_i;
        CFG_FILL_VALUE:   fill_value_q   <= cfg_wdata_i;
        CFG_GAP_LIMIT:    gap_limit_q    <= cfg_wdata_i[7:0];
        CFG_LENGTH_SCALE: length_scale_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // pixel store
  logic        ram_we;
  logic [23:0] ram_rdata;

  assign ram_we = cmd_i.wr && in_image(item_i.pos_x, item_i.pos_y);

  // line stepper
  logic [7:0]            x_q, y_q, xe_q, ye_q, dx_q, dy_q;
  logic                  sx_q, sy_q;
  logic signed [ErrW-1:0] err_q, err_d, dxs, dys;
  logic                  xstep, ystep;
  logic [7:0]            dx_in, dy_in;
  logic                  at_end;

  lpms_ram #(
    .Width (24),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pix_addr(item_i.pos_x, item_i.pos_y)),
    .wdata_i ({item_i.mask_value, item_i.chlorophyll}),
    .re_i    (cmd_i.step),
    .raddr_i (pix_addr(x_q, y_q)),
    .rdata_o (ram_rdata)
  );

  assign dx_in  = (item_i.end_x > item_i.pos_x) ? item_i.end_x - item_i.pos_x
                                                : item_i.pos_x - item_i.end_x;
  assign dy_in  = (item_i.end_y > item_i.pos_y) ? item_i.end_y - item_i.pos_y
                                                : item_i.pos_y - item_i.end_y;
  assign dxs    = $signed({3'b000, dx_q});
  assign dys    = $signed({3'b000, dy_q});
  assign xstep  = err_q > -dxs;
  assign ystep  = err_q < dys;
  assign err_d  = err_q - (xstep ? dys : '0) + (ystep ? dxs : '0);
  assign at_end = (x_q == xe_q) && (y_q == ye_q);
  assign sts_o.at_end = at_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= item_i.pos_x;
      y_q  <= item_i.pos_y;
      xe_q <= item_i.end_x;
      ye_q <= item_i.end_y;
      dx_q <= dx_in;
      dy_q <= dy_in;
      sx_q <= item_i.pos_x < item_i.end_x;
      sy_q <= item_i.pos_y < item_i.end_y;
      err_q <= (dx_in > dy_in) ? $signed(ErrW'(dx_in >> 1)) : -$signed(ErrW'(dy_in >> 1));
    end else if (cmd_i.step && !at_end) begin
      err_q <= err_d;
      if (xstep) begin
        x_q <= sx_q ? x_q + 8'd1 : x_q - 8'd1;
      end
      if (ystep) begin
        y_q <= sy_q ? y_q + 8'd1 : y_q - 8'd1;
      end
    end
  end

  // read tracking
  logic rv_q, inb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      inb_q <= in_image(x_q, y_q);
    end
  end

  // profile statistics
  logic [15:0]   max_q, max_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]    gap_q, gap_d;
  lpms_phase_e   phase_q, phase_d;
  logic [15:0]   len_q;
  logic [ProdW-1:0] prod;

  always_comb begin
    logic [23:0] pix;
    logic [15:0] chl;
    logic        marked, unmarked;
    pix      = inb_q ? ram_rdata : '0;
    chl      = pix[15:0];
    marked   = pix[23:16] == MaskMarked;
    unmarked = pix[23:16] == MaskUnmarked;
    max_d    = max_q;
    cnt_d    = cnt_q;
    gap_d    = gap_q;
    phase_d  = phase_q;
    if (chl > max_q && chl != fill_value_q) begin
      max_d = chl;
    end
    if (marked && phase_d == PH_IDLE) begin
      phase_d = PH_RUN;
    end
    if (unmarked && phase_d == PH_RUN) begin
      phase_d = PH_GAP;
      gap_d   = '0;
    end
    if (phase_d == PH_GAP && gap_d != 8'hFF) begin
      gap_d = gap_d + 8'd1;
    end
    if (phase_d == PH_GAP && marked && gap_d < gap_limit_q) begin
      phase_d = PH_RUN;
      cnt_d   = cnt_d + CntW'(gap_d);
    end
    if (marked) begin
      cnt_d = cnt_d + CntW'(1);
    end
  end

  assign prod = ProdW'(cnt_q) * ProdW'(length_scale_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      max_q   <= max_floor_q;
      cnt_q   <= '0;
      gap_q   <= '0;
      phase_q <= PH_IDLE;
    end else if (rv_q) begin
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      gap_q   <= gap_d;
      phase_q <= phase_d;
    end
    if (cmd_i.scale) begin
      // at most two counts per pixel of an 8-bit line, so the product stays below 65535
      len_q <= 16'(prod);
    end
  end

  assign result_o.max_chlorophyll  = max_q;
  assign result_o.extension_length = len_q;
  assign result_o.end_row          = y_q;

  `LPMS_NEVER(a_write_during_walk, clk_i, rst_ni, cmd_i.wr && cmd_i.step, "pixel write during walk")
  `LPMS_ASSERT(a_read_follows_step, clk_i, rst_ni, rv_q == $past(cmd_i.step), "read data flag out of step")
  `LPMS_ASSERT(a_load_clears_count, clk_i, rst_ni, cmd_i.load |=> (cnt_q == '0), "count not cleared at trace start")

endmodule

// ----- tb/line_profile_mask_stats_test.sv -----
// ----------------------------------------------------------------------------
// line_profile_mask_stats_test
// self-checking bench for the pixel store and bresenham line profiler. a short
// table of directed beats runs first, then random sequences paint the pixels
// of a line, mostly with marked runs and gaps near the bridging limit, and
// trace it. every trace result is compared with a table value or a local
// profile model of the block, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module line_profile_mask_stats_test;
  import lpms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriod    = 10;
  localparam int TargetBeats   = 700;
  localparam int TracesPerSet  = 6;
  localparam int WatchdogLimit = 3000;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    lpms_in_t    beat;
    bit          typed;
    lpms_out_t   want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  lpms_in_t    item_i;
  logic        done_o;
  lpms_out_t   result_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  logic [23:0] pixel_mem   [0:65535];
  bit          pix_written [0:65535];
  logic [15:0] floor_r;
  logic [15:0] fill_r;
  logic [7:0]  gap_lim_r;
  logic [3:0]  scale_r;

  lpms_out_t   expected_profiles[$];
  lpms_out_t   head_profile;
  stim_row_t   directed_rows[$];
  bit          steady;
  int          beats_sent;
  int          traces_sent;
  int          profiles_checked;
  int          reg_settings;
  int          fails;
  int          stall_cycles;

  line_profile_mask_stats u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic void walk_line(input lpms_in_t b, output logic [15:0] pts[$]);
    int x, y, xe, ye, dx, dy, sx, sy, err, e2;
    x  = b.pos_x;
    y  = b.pos_y;
    xe = b.end_x;
    ye = b.end_y;
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    pts = {};
    forever begin
      pts.push_back({y[7:0], x[7:0]});
      if (x == xe && y == ye) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y += sy;
      end
    end
  endfunction

  function automatic lpms_out_t profile_line(input lpms_in_t b);
    logic [15:0] pts[$];
    logic [23:0] px;
    logic [15:0] chl;
    logic [15:0] peak;
    logic [7:0]  m;
    int unsigned count, gap_n, len;
    lpms_phase_e ph;
    lpms_out_t   r;
    walk_line(b, pts);
    peak  = floor_r;
    count = 0;
    gap_n = 0;
    ph    = PH_IDLE;
    foreach (pts[i]) begin
      px  = pixel_mem[pts[i]];
      chl = px[15:0];
      m   = px[23:16];
      if (chl > peak && chl != fill_r) peak = chl;
      if (m == MaskMarked && ph == PH_IDLE) ph = PH_RUN;
      if (m == MaskUnmarked && ph == PH_RUN) begin
        ph    = PH_GAP;
        gap_n = 0;
      end
      if (ph == PH_GAP && gap_n < 255) gap_n++;
      if (ph == PH_GAP && m == MaskMarked && gap_n < gap_lim_r) begin
        ph    = PH_RUN;
        count += gap_n;
      end
      if (m == MaskMarked) count++;
    end
    len = count * scale_r;
    if (len > 65535) len = 65535;
    r.max_chlorophyll  = peak;
    r.extension_length = len[15:0];
    r.end_row          = pts[pts.size() - 1][15:8];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [7:0] odd_mask();
    return 8'($urandom_range(1, 254));
  endfunction

  function automatic logic [15:0] pick_chl();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return fill_r;
    if (r == 3) return 16'hFFFF;
    if (r == 4) return 16'h0000;
    if (r == 5) return 16'hFFFE;
    if (r == 6) return floor_r + 16'd1;
    return 16'($urandom);
  endfunction

  function automatic lpms_in_t pixel_beat(input logic [15:0] addr, input logic [7:0] m,
                                          input logic [15:0] c);
    lpms_in_t b;
    b.command     = CMD_WRITE;
    b.pos_x       = addr[7:0];
    b.pos_y       = addr[15:8];
    b.end_x       = 8'($urandom);
    b.end_y       = 8'($urandom);
    b.mask_value  = m;
    b.chlorophyll = c;
    return b;
  endfunction

  function automatic int step_from(input int c, input int d);
    if (c + d > 255 || (c >= d && $urandom_range(0, 1) == 1)) return c - d;
    return c + d;
  endfunction

  function automatic void row_cfg(input logic [1:0] idx, input logic [15:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_wr(input logic [7:0] x, input logic [7:0] y,
                                 input logic [7:0] m, input logic [15:0] c);
    stim_row_t r;
    r = '{default: '0};
    r.beat = '{command: CMD_WRITE, pos_x: x, pos_y: y, end_x: ~x, end_y: ~y,
               mask_value: m, chlorophyll: c};
    directed_rows.push_back(r);
  endfunction

  function automatic void row_tr(input logic [7:0] x, input logic [7:0] y,
                                 input logic [7:0] xe, input logic [7:0] ye,
                                 input bit typed, input lpms_out_t want);
    stim_row_t r;
    r = '{default: '0};
    r.beat  = '{command: CMD_TRACE, pos_x: x, pos_y: y, end_x: xe, end_y: ye,
                mask_value: 8'h5A, chlorophyll: 16'hA5A5};
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  task automatic issue(input lpms_in_t b, input bit typed, input lpms_out_t want);
    int idle_n;
    idle_n = pick_idle();
    @(negedge clk_i);
    if (idle_n > 0) begin
      start <= 1'b0;
      repeat (idle_n) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= b;
    do @(posedge clk_i); while (busy);
    beats_sent++;
    if (b.command == CMD_TRACE) begin
      traces_sent++;
      expected_profiles.push_back(typed ? want : profile_line(b));
    end else begin
      pixel_mem[{b.pos_y, b.pos_x}]   = {b.mask_value, b.chlorophyll};
      pix_written[{b.pos_y, b.pos_x}] = 1'b1;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_profiles.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_FLOOR:    floor_r   = v;
      CFG_FILL_VALUE:   fill_r    = v;
      CFG_GAP_LIMIT:    gap_lim_r = v[7:0];
      CFG_LENGTH_SCALE: scale_r   = v[3:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_profiles.size() == 0) begin
        $error("result beat with no trace pending");
        fails++;
      end else begin
        head_profile = expected_profiles.pop_front();
        profiles_checked++;
        check_field("max_chlorophyll", head_profile.max_chlorophyll,
                    result_o.max_chlorophyll);
        check_field("extension_length", head_profile.extension_length,
                    result_o.extension_length);
        check_field("end_row", {8'h00, head_profile.end_row}, {8'h00, result_o.end_row});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [15:0] pts[$];
    logic [7:0]  masks[$];
    lpms_in_t    tr;
    int          len_px, d, k, seq_n, x0, y0, pick;
    bit          along_x;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_MAX_FLOOR;
    cfg_wdata_i = '0;
    floor_r     = MaxFloorReset;
    fill_r      = FillValueReset;
    gap_lim_r   = GapLimitReset;
    scale_r     = LengthScaleReset;
    steady      = 1'b0;
    beats_sent  = 0;
    traces_sent = 0;
    profiles_checked = 0;
    reg_settings = 0;
    fails        = 0;
    seq_n        = 0;

    // directed table, reset register values first
    row_wr(8'd0, 8'd0, MaskMarked, 16'hFFFF);
    row_tr(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, '{16'd1, 16'd4, 8'd0});
    row_wr(8'd255, 8'd255, MaskUnmarked, 16'hFFFE);
    row_tr(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{16'hFFFE, 16'd0, 8'd255});
    row_wr(8'd1, 8'd0, MaskUnmarked, 16'h0000);
    row_wr(8'd2, 8'd0, 8'h7F, 16'h1234);
    row_wr(8'd3, 8'd0, MaskMarked, 16'h8000);
    row_tr(8'd0, 8'd0, 8'd3, 8'd0, 1'b0, '0);
    row_wr(8'd0, 8'd1, 8'h80, 16'h7FFF);
    row_wr(8'd1, 8'd1, MaskMarked, 16'h0001);
    row_tr(8'd3, 8'd0, 8'd0, 8'd0, 1'b0, '0);
    // no bridging at all
    row_cfg(CFG_GAP_LIMIT, 16'd0);
    row_tr(8'd0, 8'd0, 8'd3, 8'd0, 1'b0, '0);
    row_cfg(CFG_LENGTH_SCALE, 16'd0);
    row_tr(8'd0, 8'd0, 8'd3, 8'd0, 1'b1, '{16'h8000, 16'd0, 8'd0});
    row_cfg(CFG_LENGTH_SCALE, 16'd15);
    row_cfg(CFG_GAP_LIMIT, 16'd255);
    row_cfg(CFG_MAX_FLOOR, 16'd65534);
    row_cfg(CFG_FILL_VALUE, 16'd0);
    row_tr(8'd0, 8'd0, 8'd1, 8'd1, 1'b0, '0);
    row_tr(8'd0, 8'd1, 8'd3, 8'd0, 1'b0, '0);
    row_wr(8'd254, 8'd255, MaskMarked, 16'hFFFF);
    row_tr(8'd255, 8'd255, 8'd254, 8'd255, 1'b0, '0);
    row_cfg(CFG_MAX_FLOOR, 16'd0);
    row_cfg(CFG_FILL_VALUE, 16'hFFFF);
    row_tr(8'd254, 8'd255, 8'd255, 8'd255, 1'b0, '0);
    row_tr(8'd0, 8'd1, 8'd0, 8'd0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        reg_settings++;
      end else begin
        issue(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    while (beats_sent < TargetBeats) begin
      if (seq_n % TracesPerSet == 0) begin
        drain();
        pick = $urandom_range(0, 4);
        write_reg(CFG_MAX_FLOOR, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd65534 :
                  (pick == 2) ? 16'd1 : (pick == 3) ? 16'($urandom_range(0, 300)) :
                  16'($urandom_range(0, 65534)));
        pick = $urandom_range(0, 3);
        write_reg(CFG_FILL_VALUE, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                  16'($urandom));
        pick = $urandom_range(0, 6);
        write_reg(CFG_GAP_LIMIT, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
                  (pick == 2) ? 16'd2 : (pick == 3) ? 16'd255 : (pick == 4) ? 16'd20 :
                  16'($urandom_range(1, 30)));
        pick = $urandom_range(0, 4);
        write_reg(CFG_LENGTH_SCALE, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
                  (pick == 2) ? 16'd15 : 16'($urandom_range(1, 15)));
        reg_settings++;
      end
      seq_n++;
      steady = ($urandom_range(0, 4) == 0);

      // pick the line
      tr = '{command: CMD_TRACE, pos_x: '0, pos_y: '0, end_x: '0, end_y: '0,
             mask_value: 8'($urandom), chlorophyll: 16'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        tr.pos_x = 8'($urandom);
        tr.pos_y = 8'($urandom);
        tr.end_x = 8'($urandom);
        tr.end_y = 8'($urandom);
      end else begin
        len_px  = (pick < 85) ? $urandom_range(1, 20) : $urandom_range(21, 80);
        d       = len_px - 1;
        x0      = $urandom_range(0, 255);
        y0      = $urandom_range(0, 255);
        along_x = $urandom_range(0, 1);
        tr.pos_x = 8'(x0);
        tr.pos_y = 8'(y0);
        if (along_x) begin
          tr.end_x = 8'(step_from(x0, d));
          tr.end_y = 8'(step_from(y0, $urandom_range(0, d)));
        end else begin
          tr.end_y = 8'(step_from(y0, d));
          tr.end_x = 8'(step_from(x0, $urandom_range(0, d)));
        end
      end
      walk_line(tr, pts);

      if ($urandom_range(0, 9) < 7) begin
        // marked runs split by gaps close to the bridging limit
        masks = {};
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) masks.push_back(8'($urandom));
        while (masks.size() < pts.size()) begin
          repeat ($urandom_range(1, 4))
            masks.push_back(($urandom_range(0, 6) == 0) ? odd_mask() : MaskMarked);
          if (gap_lim_r >= 2 && $urandom_range(0, 1) == 1) begin
            k = gap_lim_r - 2 + $urandom_range(0, 2);
          end else begin
            k = $urandom_range(1, 6);
          end
          masks.push_back(MaskUnmarked);
          repeat (k - 1)
            masks.push_back(($urandom_range(0, 2) == 0) ? odd_mask() : MaskUnmarked);
        end
        foreach (pts[i]) issue(pixel_beat(pts[i], masks[i], pick_chl()), 1'b0, '0);
      end else begin
        // fill only what is missing, random masks, a few rewrites
        foreach (pts[i]) begin
          if (!pix_written[pts[i]] || $urandom_range(0, 4) == 0) begin
            pick = $urandom_range(0, 9);
            issue(pixel_beat(pts[i], (pick < 4) ? MaskMarked : (pick < 8) ? MaskUnmarked :
                             8'($urandom), pick_chl()), 1'b0, '0);
          end
        end
      end

      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          issue(pixel_beat(16'($urandom), 8'($urandom), 16'($urandom)), 1'b0, '0);

      issue(tr, 1'b0, '0);
    end

    drain();
    repeat (8) @(negedge clk_i);
    $display("%0d beats issued, %0d of them traces, over %0d register settings",
             beats_sent, traces_sent, reg_settings);
    $display("%0d trace results compared field by field", profiles_checked);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
